@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the list block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ sv/bdll_pkg.sv @@
// ----------------------------------------------------------------------------
// bdll_pkg
// types and codes shared by the bounded doubly linked list modules
// ----------------------------------------------------------------------------
package bdll_pkg;

  // operation codes
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_INSERT     = 3'd2;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [2:0] MODE_POP_BACK   = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] value;
    logic [6:0]  position;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  item_count;
    logic [31:0] front_value;
    logic [31:0] back_value;
  } rsp_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_WALK,
    S_W_NEW,
    S_W_PREV,
    S_W_NEXT,
    S_POP_LINK,
    S_POP_DATA,
    S_POP_FREE,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    ADD_FRONT,
    ADD_BACK,
    ADD_INSIDE
  } add_kind_t;

  // per-field write enables of a node entry
  typedef struct packed {
    logic data;
    logic next;
    logic prev;
  } node_wen_t;

  typedef struct packed {
    logic take;
    logic give;
  } stack_cmd_t;

endpackage

@@ sv/bdll_node_mem.sv @@
// ----------------------------------------------------------------------------
// bdll_node_mem
// node store: data word plus next and prev links, per-field write enables
// ----------------------------------------------------------------------------
module bdll_node_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic                  clk,
  input  logic [AW-1:0]         raddr,
  output logic [DW-1:0]         rd_data,
  output logic [AW-1:0]         rd_next,
  output logic [AW-1:0]         rd_prev,
  input  logic [AW-1:0]         waddr,
  input  bdll_pkg::node_wen_t   wen,
  input  logic [DW-1:0]         wd_data,
  input  logic [AW-1:0]         wd_next,
  input  logic [AW-1:0]         wd_prev
);

  typedef struct packed {
    logic [DW-1:0] data;
    logic [AW-1:0] next;
    logic [AW-1:0] prev;
  } node_t;

  node_t mem [DEPTH];
  node_t rd_node;

  always_ff @(posedge clk) begin
    if (wen.data) begin
      mem[waddr].data <= wd_data;
    end
    if (wen.next) begin
      mem[waddr].next <= wd_next;
    end
    if (wen.prev) begin
      mem[waddr].prev <= wd_prev;
    end
  end

  always_ff @(posedge clk) begin
    rd_node <= mem[raddr];
  end

  assign rd_data = rd_node.data;
  assign rd_next = rd_node.next;
  assign rd_prev = rd_node.prev;

endmodule

@@ sv/bdll_free_stack.sv @@
// ----------------------------------------------------------------------------
// bdll_free_stack
// stack of free slot numbers; entries below the low-water mark were never
// written and read as their own index
// ----------------------------------------------------------------------------
module bdll_free_stack #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bdll_pkg::stack_cmd_t cmd,
  input  logic [AW-1:0]        give_slot,
  output logic [AW-1:0]        take_slot
);

  logic [AW-1:0] mem [DEPTH];
  logic [CW-1:0] top;
  logic [CW-1:0] lowmark;
  logic [CW-1:0] top_m1;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] rd_word;

  assign top_m1 = top - CW'(1);
  assign rd_idx = top_m1[AW-1:0];

  // read data comes from the previous cycle's top, which a take or a give changes
  assign take_slot = (top_m1 < lowmark) ? rd_idx : rd_word;

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_idx];
    if (cmd.give) begin
      mem[top[AW-1:0]] <= give_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top     <= CW'(DEPTH);
      lowmark <= CW'(DEPTH);
    end else if (cmd.take) begin
      top <= top_m1;
      if (top_m1 < lowmark) begin
        lowmark <= top_m1;
      end
    end else if (cmd.give) begin
      top <= top + CW'(1);
    end
  end

endmodule

@@ sv/bounded_doubly_linked_list.sv @@
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list
// ordered list of up to CAPACITY words in linked slots with a free-slot stack
// ----------------------------------------------------------------------------
//  channel  dir  handshake            word
//  req      in   req_valid/req_ready  mode, value, position
//  rsp      out  rsp_valid/rsp_ready  status, item_count, front_value, back_value
//
//  a push or an end insert takes a free slot, then writes the node and the
//  links of its neighbours; an inside insert first walks k links, at most
//  CAPACITY/2 - 1, one per cycle through the single read port of the node
//  memory; a pop relinks the new end unless one element is left; error and
//  unknown-mode words go straight to rsp. one word at a time, back in idle
//  before the next accept; a done word waits in its last state while rsp
//  holds an untaken result. reset clears control; node memory is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_doubly_linked_list #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bdll_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output bdll_pkg::rsp_word_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int DW = DATA_WIDTH;

  bdll_pkg::state_t     state, state_next;
  bdll_pkg::add_kind_t  dec_add;
  bdll_pkg::state_t     dec_state;
  logic [1:0]           dec_status;

  logic [CW-1:0] length;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [DW-1:0] front_data;
  logic [DW-1:0] back_data;
  logic [1:0]    status;
  logic [DW-1:0] item_value;
  logic          pop_head;
  logic [AW-1:0] slot;
  logic [AW-1:0] cur;
  logic          walk_fwd;
  logic [CW-1:0] steps;
  logic [AW-1:0] link_prev;
  logic [AW-1:0] link_next;
  logic          has_prev;
  logic          has_next;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] len_ext;
  logic          full;
  logic          from_head;
  logic [CW-1:0] walk_steps;

  logic [AW-1:0]        node_raddr;
  logic [DW-1:0]        rd_data;
  logic [AW-1:0]        rd_next;
  logic [AW-1:0]        rd_prev;
  logic [AW-1:0]        node_waddr;
  bdll_pkg::node_wen_t  node_wen;
  logic [DW-1:0]        node_wd_data;
  logic [AW-1:0]        node_wd_next;
  logic [AW-1:0]        node_wd_prev;
  bdll_pkg::stack_cmd_t stack_cmd;
  logic [AW-1:0]        take_slot;
  logic [AW-1:0]        walk_next;
  logic [AW-1:0]        pop_end;
  logic                 rsp_load;

  logic                 is_pop;
  logic                 pop_empty_req;
  logic                 empty_flagged;
  logic                 in_walk;
  logic                 in_add_end;

  bdll_node_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DW)
  ) u_node_mem (
    .clk     (clk),
    .raddr   (node_raddr),
    .rd_data (rd_data),
    .rd_next (rd_next),
    .rd_prev (rd_prev),
    .waddr   (node_waddr),
    .wen     (node_wen),
    .wd_data (node_wd_data),
    .wd_next (node_wd_next),
    .wd_prev (node_wd_prev)
  );

  bdll_free_stack #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .CW    (CW)
  ) u_free_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (stack_cmd),
    .give_slot (slot),
    .take_slot (take_slot)
  );

  assign pos_ext    = PW'(req.position);
  assign len_ext    = PW'(length);
  assign full       = (length == CW'(CAPACITY));
  assign from_head  = (pos_ext < (len_ext >> 1));
  assign walk_steps = from_head ? CW'(pos_ext) : CW'(len_ext - pos_ext - PW'(1));
  assign walk_next  = walk_fwd ? rd_next : rd_prev;
  assign pop_end    = pop_head ? rd_next : rd_prev;

  // request decode
  always_comb begin
    dec_status = bdll_pkg::ST_DONE;
    dec_state  = bdll_pkg::S_RESP;
    dec_add    = bdll_pkg::ADD_FRONT;
    case (req.mode)
      bdll_pkg::MODE_PUSH_FRONT, bdll_pkg::MODE_PUSH_BACK: begin
        dec_add = (req.mode == bdll_pkg::MODE_PUSH_FRONT) ? bdll_pkg::ADD_FRONT
                                                           : bdll_pkg::ADD_BACK;
        if (full) begin
          dec_status = bdll_pkg::ST_FULL;
        end else begin
          dec_state = bdll_pkg::S_SLOT;
        end
      end
      bdll_pkg::MODE_INSERT: begin
        if (pos_ext > len_ext) begin
          dec_status = bdll_pkg::ST_RANGE;
        end else if (full) begin
          dec_status = bdll_pkg::ST_FULL;
        end else begin
          dec_state = bdll_pkg::S_SLOT;
          if (pos_ext == '0) begin
            dec_add = bdll_pkg::ADD_FRONT;
          end else if (pos_ext == len_ext) begin
            dec_add = bdll_pkg::ADD_BACK;
          end else begin
            dec_add = bdll_pkg::ADD_INSIDE;
          end
        end
      end
      bdll_pkg::MODE_POP_FRONT, bdll_pkg::MODE_POP_BACK: begin
        if (length == '0) begin
          dec_status = bdll_pkg::ST_EMPTY;
        end else if (length == CW'(1)) begin
          dec_state = bdll_pkg::S_POP_FREE;
        end else begin
          dec_state = bdll_pkg::S_POP_LINK;
        end
      end
      default: begin
        dec_state = bdll_pkg::S_RESP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdll_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    node_raddr   = cur;
    node_waddr   = slot;
    node_wen     = '0;
    node_wd_data = item_value;
    node_wd_next = link_next;
    node_wd_prev = link_prev;
    stack_cmd    = '0;
    rsp_load     = 1'b0;
    case (state)
      bdll_pkg::S_IDLE: begin
        req_ready = !rst;
        if (req.mode == bdll_pkg::MODE_POP_FRONT) begin
          node_raddr = head;
        end else if (req.mode == bdll_pkg::MODE_POP_BACK) begin
          node_raddr = tail;
        end else begin
          node_raddr = from_head ? head : tail;
        end
        if (req_valid) begin
          state_next = dec_state;
        end
      end
      bdll_pkg::S_SLOT: begin
        stack_cmd.take = 1'b1;
        state_next = (has_prev && has_next) ? bdll_pkg::S_WALK : bdll_pkg::S_W_NEW;
      end
      bdll_pkg::S_WALK: begin
        // one link per cycle, next address straight from the read data
        if (steps == '0) begin
          state_next = bdll_pkg::S_W_NEW;
        end else begin
          node_raddr = walk_next;
        end
      end
      bdll_pkg::S_W_NEW: begin
        node_wen   = '{data: 1'b1, next: 1'b1, prev: 1'b1};
        state_next = bdll_pkg::S_W_PREV;
      end
      bdll_pkg::S_W_PREV: begin
        node_waddr    = link_prev;
        node_wen.next = has_prev;
        node_wd_next  = slot;
        state_next    = bdll_pkg::S_W_NEXT;
      end
      bdll_pkg::S_W_NEXT: begin
        node_waddr    = link_next;
        node_wen.prev = has_next;
        node_wd_prev  = slot;
        state_next    = bdll_pkg::S_RESP;
      end
      bdll_pkg::S_POP_LINK: begin
        node_raddr = pop_end;
        state_next = bdll_pkg::S_POP_DATA;
      end
      bdll_pkg::S_POP_DATA: begin
        state_next = bdll_pkg::S_POP_FREE;
      end
      bdll_pkg::S_POP_FREE: begin
        stack_cmd.give = 1'b1;
        state_next = bdll_pkg::S_RESP;
      end
      bdll_pkg::S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = bdll_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bdll_pkg::S_IDLE;
      end
    endcase
  end

  // list registers and per-word working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
      head   <= '0;
      tail   <= '0;
    end else begin
      case (state)
        bdll_pkg::S_IDLE: begin
          if (req_valid) begin
            status     <= dec_status;
            item_value <= DW'(req.value);
            pop_head   <= (req.mode == bdll_pkg::MODE_POP_FRONT);
            slot       <= node_raddr;
            cur        <= node_raddr;
            walk_fwd   <= from_head;
            steps      <= walk_steps;
            case (dec_add)
              bdll_pkg::ADD_FRONT: begin
                has_prev  <= 1'b0;
                has_next  <= (length != '0);
                link_next <= head;
              end
              bdll_pkg::ADD_BACK: begin
                has_prev  <= (length != '0);
                has_next  <= 1'b0;
                link_prev <= tail;
              end
              default: begin
                has_prev <= 1'b1;
                has_next <= 1'b1;
              end
            endcase
          end
        end
        bdll_pkg::S_SLOT: begin
          slot <= take_slot;
        end
        bdll_pkg::S_WALK: begin
          if (steps == '0) begin
            link_next <= cur;
            link_prev <= rd_prev;
          end else begin
            cur   <= walk_next;
            steps <= steps - CW'(1);
          end
        end
        bdll_pkg::S_W_NEXT: begin
          if (!has_prev) begin
            head       <= slot;
            front_data <= item_value;
          end
          if (!has_next) begin
            tail      <= slot;
            back_data <= item_value;
          end
          length <= length + CW'(1);
        end
        bdll_pkg::S_POP_LINK: begin
          if (pop_head) begin
            head <= pop_end;
          end else begin
            tail <= pop_end;
          end
        end
        bdll_pkg::S_POP_DATA: begin
          if (pop_head) begin
            front_data <= rd_data;
          end else begin
            back_data <= rd_data;
          end
        end
        bdll_pkg::S_POP_FREE: begin
          length <= length - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status      <= status;
      rsp.item_count  <= 7'(length);
      rsp.front_value <= (length != '0) ? 32'(front_data) : '0;
      rsp.back_value  <= (length != '0) ? 32'(back_data) : '0;
    end
  end

  assign is_pop        = (req.mode == bdll_pkg::MODE_POP_FRONT) ||
                         (req.mode == bdll_pkg::MODE_POP_BACK);
  assign pop_empty_req = req_valid && req_ready && (length == '0) && is_pop;
  assign empty_flagged = (state == bdll_pkg::S_RESP) && (status == bdll_pkg::ST_EMPTY);
  assign in_walk       = (state == bdll_pkg::S_WALK);
  assign in_add_end    = (state == bdll_pkg::S_W_NEXT);

  `ASSERT_CLK(a_len_bound, clk, rst, length <= CW'(CAPACITY), "length above capacity")
  `ASSERT_CLK(a_walk_bound, clk, rst, in_walk |-> (steps <= (length >> 1)), "walk too long")
  `ASSERT_CLK(a_pop_empty, clk, rst, pop_empty_req |=> empty_flagged, "empty pop not flagged")
  `ASSERT_CLK(a_add_count, clk, rst, in_add_end |=> (length == $past(length) + CW'(1)), "no count bump")

endmodule
